/* hdl/utfd_pkg.sv */
// ----------------------------------------------------------------------------
// utfd_pkg
// Shared types and constants for the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package utfd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    localparam logic [CP_W-1:0] SUBST_CP = 21'd63;
    localparam logic [CP_W-1:0] MIN_CP2  = 21'h00080;
    localparam logic [CP_W-1:0] MIN_CP3  = 21'h00800;
    localparam logic [CP_W-1:0] SURR_LO  = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI  = 21'h0DFFF;
    localparam logic [CP_W-1:0] MIN_CP4  = 21'h10000;
    localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // Results caused by one byte: flush_cnt substitutes, then an optional tail.
    typedef struct packed {
        logic [1:0]      flush_cnt;
        logic            tail_valid;
        logic [CP_W-1:0] tail_cp;
        logic            tail_subst;
    } burst_t;

endpackage

/* hdl/utfd_in_if.sv */
// ----------------------------------------------------------------------------
// utfd_in_if
// Byte channel: one text byte per transaction with an end-of-text flag.
// ----------------------------------------------------------------------------
interface utfd_in_if
    import utfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* hdl/utfd_out_if.sv */
// ----------------------------------------------------------------------------
// utfd_out_if
// Code point channel: one decoded scalar value per transaction.
// ----------------------------------------------------------------------------
interface utfd_out_if
    import utfd_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            substituted;
    logic            last_of_run;

    modport source (output valid, output code_point, output substituted,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input substituted,
                    input last_of_run, output ready);
endinterface

/* hdl/utfd_decode.sv */
// ----------------------------------------------------------------------------
// utfd_decode
// Sequence state and single-pass decode of one byte into a result burst.
// ----------------------------------------------------------------------------
module utfd_decode
    import utfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              end_of_text,
    output burst_t            burst
);

    logic [2:0]      seq_len_reg, seq_len_next;
    logic [1:0]      seen_reg, seen_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    logic            is_cont;
    logic            is_ascii;
    logic            lead2, lead3, lead4;
    logic [CP_W-1:0] shifted;
    logic [2:0]      seen_inc;
    logic            bad;

    assign is_cont  = (text_byte[7:6] == 2'b10);
    assign is_ascii = ~text_byte[7];
    assign lead2    = (text_byte[7:5] == 3'b110);
    assign lead3    = (text_byte[7:4] == 4'b1110);
    assign lead4    = (text_byte[7:3] == 5'b11110);
    assign shifted  = {partial_reg[CP_W-7:0], text_byte[5:0]};
    assign seen_inc = {1'b0, seen_reg} + 3'd1;

    always_comb
    begin
        case (seq_len_reg)
            LEN_TWO:   bad = (shifted < MIN_CP2);
            LEN_THREE: bad = (shifted < MIN_CP3) || ((shifted >= SURR_LO) && (shifted <= SURR_HI));
            default:   bad = (shifted < MIN_CP4) || (shifted > MAX_CP);
        endcase
    end

    always_comb
    begin
        burst        = '0;
        burst.tail_cp = SUBST_CP;
        seq_len_next = seq_len_reg;
        seen_next    = seen_reg;
        partial_next = partial_reg;

        if ((seq_len_reg != LEN_NONE) && is_cont)
        begin
            if (seen_inc == seq_len_reg)
            begin
                burst.tail_valid = 1'b1;
                burst.tail_subst = bad;
                burst.tail_cp    = bad ? SUBST_CP : shifted;
                seq_len_next     = LEN_NONE;
                seen_next        = '0;
                partial_next     = '0;
            end
            else if (end_of_text)
            begin
                burst.flush_cnt  = seen_reg;
                burst.tail_valid = 1'b1;
                burst.tail_subst = 1'b1;
                seq_len_next     = LEN_NONE;
                seen_next        = '0;
                partial_next     = '0;
            end
            else
            begin
                seen_next    = seen_inc[1:0];
                partial_next = shifted;
            end
        end
        else
        begin
            // no open or a broken sequence: flush any buffered bytes, then treat byte as a lead
            if (seq_len_reg != LEN_NONE)
                burst.flush_cnt = seen_reg;
            seq_len_next = LEN_NONE;
            seen_next    = '0;
            partial_next = '0;
            if (is_ascii)
            begin
                burst.tail_valid = 1'b1;
                burst.tail_cp    = {{(CP_W-BYTE_W){1'b0}}, text_byte};
            end
            else if ((lead2 || lead3 || lead4) && !end_of_text)
            begin
                seen_next = 2'd1;
                if (lead2)
                begin
                    seq_len_next = LEN_TWO;
                    partial_next = {{(CP_W-5){1'b0}}, text_byte[4:0]};
                end
                else if (lead3)
                begin
                    seq_len_next = LEN_THREE;
                    partial_next = {{(CP_W-4){1'b0}}, text_byte[3:0]};
                end
                else
                begin
                    seq_len_next = LEN_FOUR;
                    partial_next = {{(CP_W-3){1'b0}}, text_byte[2:0]};
                end
            end
            else
            begin
                burst.tail_valid = 1'b1;
                burst.tail_subst = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= LEN_NONE;
            seen_reg    <= '0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            seen_reg    <= seen_next;
            partial_reg <= partial_next;
        end
    end

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg != LEN_NONE) |-> (seen_reg != 2'd0) && ({1'b0, seen_reg} < seq_len_reg))
        else $error("open sequence with inconsistent byte count");

    a_closed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg == LEN_NONE) |-> (seen_reg == 2'd0) && (partial_reg == '0))
        else $error("closed sequence holds stale state");

    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> (seq_len_reg == LEN_NONE))
        else $error("sequence left open after end of text");

endmodule

/* hdl/utfd_emit.sv */
// ----------------------------------------------------------------------------
// utfd_emit
// Result register: holds one burst and plays it out one code point at a time.
// ----------------------------------------------------------------------------
module utfd_emit
    import utfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  burst_t       burst,
    output logic         can_load,
    utfd_out_if.source   out_ch
);

    logic [1:0]      cnt_reg;
    logic            tail_valid_reg;
    logic [CP_W-1:0] tail_cp_reg;
    logic            tail_subst_reg;

    logic            is_last;
    logic            fire;

    assign is_last = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !tail_valid_reg);
    assign fire    = out_ch.valid && out_ch.ready;

    assign out_ch.valid       = (cnt_reg != 2'd0) || tail_valid_reg;
    assign out_ch.code_point  = (cnt_reg != 2'd0) ? SUBST_CP : tail_cp_reg;
    assign out_ch.substituted = (cnt_reg != 2'd0) ? 1'b1 : tail_subst_reg;
    assign out_ch.last_of_run = is_last;

    assign can_load = !out_ch.valid || (out_ch.ready && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            tail_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg        <= burst.flush_cnt;
            tail_valid_reg <= burst.tail_valid;
        end
        else if (fire)
        begin
            if (cnt_reg != 2'd0)
                cnt_reg <= cnt_reg - 2'd1;
            else
                tail_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tail_cp_reg    <= burst.tail_cp;
            tail_subst_reg <= burst.tail_subst;
        end
    end

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!load && cnt_reg != 2'd0) |=>
            (cnt_reg == $past(cnt_reg)) || (cnt_reg == 2'($past(cnt_reg) - 2'd1)))
        else $error("substitute count skipped");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_last && !load) |=> !out_ch.valid)
        else $error("results left after last of run");

    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_last) |=> out_ch.valid)
        else $error("run ended without last flag");

endmodule

/* hdl/utf8_validating_decoder_top.sv */
// ----------------------------------------------------------------------------
// utf8_validating_decoder_top
// UTF-8 byte stream to code points, with substitution of invalid sequences.
//
//   channel | dir | payload                                    | per transaction
//   text    | in  | text_byte[7:0], end_of_text                | one byte
//   points  | out | code_point[20:0], substituted, last_of_run | one code point
//
// A byte is decoded in the cycle it is accepted; its results appear from the
// next cycle, one per cycle while points is ready.
// One byte per cycle while each byte gives at most one result and points is
// ready; a byte with more results holds text until its last result is taken.
// Reset is asynchronous, active low; no open sequence after reset.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_top
    import utfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utfd_in_if.sink    text,
    utfd_out_if.source points
);

    burst_t burst;
    logic   can_load;
    logic   accept;

    assign text.ready = can_load;
    assign accept     = text.valid && can_load;

    utfd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text.text_byte),
        .end_of_text (text.end_of_text),
        .burst       (burst)
    );

    utfd_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .burst    (burst),
        .can_load (can_load),
        .out_ch   (points)
    );

endmodule

/* tb/utf8_validating_decoder_top_test.sv */
// ----------------------------------------------------------------------------
// utf8_validating_decoder_top_test
// Self-checking bench for the UTF-8 validating decoder. A short table of
// directed bytes covers ASCII, invalid leads, sequence length extremes,
// overlong, surrogate and out-of-range values, broken and cut sequences.
// Random texts then follow, built mostly of well-formed characters with random
// content and the rest malformed or noise. Every point transaction is compared
// against its typed table value or a local decoder model. The byte sender works
// in bursts and the point receiver stalls on patterns.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_top_test;
    import utfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF_PERIOD    = 4;
    localparam int  RESET_CYCLES   = 10;
    localparam int  RANDOM_BYTES   = 450;
    localparam int  DRAIN_CYCLES   = 16;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  N_DIRECTED     = 27;
    localparam logic TYPED = 1'b1;
    localparam logic MODEL = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
        logic              typed;
        logic [CP_W-1:0]   code_point;
        logic              substituted;
    } text_row_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            substituted;
        logic            last_of_run;
    } point_t;

    logic clk;
    logic rst_n;

    utfd_in_if  text_if ();
    utfd_out_if points_if ();

    utf8_validating_decoder_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .points (points_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // typed rows carry exactly one result; the others are left to the model
    text_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, TYPED, 21'h00000, 1'b0},
        '{8'h7F, 1'b0, TYPED, 21'h0007F, 1'b0},
        '{8'h3F, 1'b0, TYPED, SUBST_CP,  1'b0},
        '{8'h80, 1'b0, TYPED, SUBST_CP,  1'b1},
        '{8'hFF, 1'b0, TYPED, SUBST_CP,  1'b1},
        '{8'hC2, 1'b1, TYPED, SUBST_CP,  1'b1},
        '{8'hC2, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h80, 1'b0, TYPED, MIN_CP2,   1'b0},
        '{8'hC0, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h80, 1'b0, TYPED, SUBST_CP,  1'b1},
        '{8'hED, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'hA0, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h80, 1'b0, TYPED, SUBST_CP,  1'b1},
        '{8'hF4, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h8F, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'hBF, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'hBF, 1'b0, TYPED, MAX_CP,    1'b0},
        '{8'hF5, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h80, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h80, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h80, 1'b0, TYPED, SUBST_CP,  1'b1},
        '{8'hE2, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h82, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h41, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'hF0, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h90, 1'b0, MODEL, 21'h00000, 1'b0},
        '{8'h80, 1'b1, MODEL, 21'h00000, 1'b0}
    };

    text_row_t text_bytes_q [$];
    point_t    due_points_q [$];
    point_t    run_q [$];

    // decoder model state
    logic [2:0]      open_len;
    logic [2:0]      seen_cnt;
    logic [CP_W-1:0] partial_cp;

    int err_cnt;
    int bytes_sent;
    int points_seen;
    int subst_seen;
    int texts_made;
    int burst_left;
    int gap_left;
    int pat_left;
    int idle_cycles;
    logic [15:0] stall_pat;

    function automatic void add_result(input logic [CP_W-1:0] cp, input logic subst);
        point_t p;
        p.code_point  = cp;
        p.substituted = subst;
        p.last_of_run = 1'b0;
        run_q.push_back(p);
    endfunction

    function automatic void clear_open();
        open_len   = LEN_NONE;
        seen_cnt   = 3'd0;
        partial_cp = '0;
    endfunction

    function automatic void flush_open();
        for (int i = 0; i < int'(seen_cnt); i++) begin
            add_result(SUBST_CP, 1'b1);
        end
        clear_open();
    endfunction

    function automatic void open_lead(input logic [BYTE_W-1:0] b, input logic eot);
        logic [2:0]      len;
        logic [CP_W-1:0] payload;
        len     = LEN_NONE;
        payload = '0;
        casez (b)
            8'b0???????: add_result(CP_W'(b), 1'b0);
            8'b110?????: begin len = LEN_TWO;   payload = CP_W'(b[4:0]); end
            8'b1110????: begin len = LEN_THREE; payload = CP_W'(b[3:0]); end
            8'b11110???: begin len = LEN_FOUR;  payload = CP_W'(b[2:0]); end
            default:     add_result(SUBST_CP, 1'b1);
        endcase
        if (len != LEN_NONE) begin
            if (eot) begin
                add_result(SUBST_CP, 1'b1);
            end else begin
                open_len   = len;
                seen_cnt   = 3'd1;
                partial_cp = payload;
            end
        end
    endfunction

    // results caused by one accepted byte land in run_q
    function automatic void decode_text_byte(input logic [BYTE_W-1:0] b, input logic eot);
        logic bad;
        run_q.delete();
        if (open_len == LEN_NONE) begin
            open_lead(b, eot);
        end else if (b[7:6] == 2'b10) begin
            partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
            seen_cnt   = seen_cnt + 3'd1;
            if (seen_cnt == open_len) begin
                case (open_len)
                    LEN_TWO:   bad = partial_cp < MIN_CP2;
                    LEN_THREE: bad = partial_cp < MIN_CP3 ||
                                     (partial_cp >= SURR_LO && partial_cp <= SURR_HI);
                    default:   bad = partial_cp < MIN_CP4 || partial_cp > MAX_CP;
                endcase
                add_result(bad ? SUBST_CP : partial_cp, bad);
                clear_open();
            end else if (eot) begin
                flush_open();
            end
        end else begin
            flush_open();
            open_lead(b, eot);
        end
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        text_row_t r;
        r             = '0;
        r.text_byte   = b;
        r.typed       = MODEL;
        text_bytes_q.push_back(r);
    endfunction

    // emits the first 'keep' bytes of a len-byte encoding of cp
    function automatic void push_sequence(input logic [CP_W-1:0] cp, input int len,
                                          input int keep);
        logic [CP_W-1:0] shifted;
        case (len)
            2:       push_byte({3'b110, cp[10:6]});
            3:       push_byte({4'b1110, cp[15:12]});
            default: push_byte({5'b11110, cp[20:18]});
        endcase
        for (int k = 1; k < keep; k++) begin
            shifted = cp >> (6 * (len - 1 - k));
            push_byte({2'b10, shifted[5:0]});
        end
    endfunction

    // byte sender
    always @(posedge clk) begin
        if (rst_n) begin
            if (text_if.valid && text_if.ready) begin
                decode_text_byte(text_bytes_q[0].text_byte, text_bytes_q[0].end_of_text);
                if (text_bytes_q[0].typed) begin
                    run_q.delete();
                    add_result(text_bytes_q[0].code_point, text_bytes_q[0].substituted);
                end
                if (run_q.size() > 0) begin
                    run_q[run_q.size() - 1].last_of_run = 1'b1;
                end
                foreach (run_q[i]) begin
                    due_points_q.push_back(run_q[i]);
                end
                void'(text_bytes_q.pop_front());
                bytes_sent++;
            end
            if (!(text_if.valid && !text_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    text_if.valid <= 1'b0;
                end else if (text_bytes_q.size() > 0) begin
                    text_if.valid       <= 1'b1;
                    text_if.text_byte   <= text_bytes_q[0].text_byte;
                    text_if.end_of_text <= text_bytes_q[0].end_of_text;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // point receiver
    always @(posedge clk) begin
        if (rst_n) begin
            if (pat_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pat = 16'hFFFF;
                    1:       stall_pat = 16'($urandom) | 16'h0001;
                    default: stall_pat = 16'h0001 << $urandom_range(0, 15);
                endcase
                pat_left = $urandom_range(16, 96);
            end
            points_if.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_left--;
        end
    end

    // point checker
    always @(posedge clk) begin
        point_t exp_p;
        if (rst_n && points_if.valid && points_if.ready) begin
            points_seen++;
            if (points_if.substituted) subst_seen++;
            if (due_points_q.size() == 0) begin
                $error("unexpected point transaction: code_point %0h", points_if.code_point);
                err_cnt++;
            end else begin
                exp_p = due_points_q.pop_front();
                if (points_if.code_point !== exp_p.code_point) begin
                    $error("code_point: expected %0h, actual %0h",
                           exp_p.code_point, points_if.code_point);
                    err_cnt++;
                end
                if (points_if.substituted !== exp_p.substituted) begin
                    $error("substituted: expected %0b, actual %0b",
                           exp_p.substituted, points_if.substituted);
                    err_cnt++;
                end
                if (points_if.last_of_run !== exp_p.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           exp_p.last_of_run, points_if.last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((text_if.valid && text_if.ready) || (points_if.valid && points_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("utf8_validating_decoder_top_test failed");
                $finish;
            end
        end
    end

    initial begin
        int              kind;
        int              nchars;
        int              len;
        logic [CP_W-1:0] cp;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        text_if.valid         = 1'b0;
        text_if.text_byte     = '0;
        text_if.end_of_text   = 1'b0;
        points_if.ready       = 1'b0;
        err_cnt               = 0;
        bytes_sent            = 0;
        points_seen           = 0;
        subst_seen            = 0;
        texts_made            = 0;
        burst_left            = 0;
        gap_left              = 0;
        pat_left              = 0;
        idle_cycles           = 0;
        stall_pat             = 16'hFFFF;
        clear_open();

        foreach (directed_rows[i]) begin
            text_bytes_q.push_back(directed_rows[i]);
        end

        while (text_bytes_q.size() < N_DIRECTED + RANDOM_BYTES) begin
            nchars = $urandom_range(1, 8);
            for (int c = 0; c < nchars; c++) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    push_byte(8'($urandom_range(0, 127)));
                end else if (kind < 50) begin
                    push_sequence(CP_W'($urandom_range(12'h080, 12'h7FF)), 2, 2);
                end else if (kind < 65) begin
                    push_sequence(CP_W'($urandom_range(16'h0800, 16'hFFFF)), 3, 3);
                end else if (kind < 78) begin
                    push_sequence(CP_W'($urandom_range(21'h10000, 21'h10FFFF)), 4, 4);
                end else if (kind < 84) begin
                    // complete sequence with unconstrained payload
                    len = $urandom_range(2, 4);
                    push_sequence(CP_W'($urandom), len, len);
                end else if (kind < 92) begin
                    // truncated sequence, usually broken by what follows or cut by end of text
                    len = $urandom_range(2, 4);
                    cp  = CP_W'($urandom);
                    push_sequence(cp, len, $urandom_range(1, len - 1));
                end else begin
                    push_byte(8'($urandom));
                end
            end
            text_bytes_q[text_bytes_q.size() - 1].end_of_text = 1'b1;
            texts_made++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (text_bytes_q.size() != 0 || due_points_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes (directed table plus %0d random texts).",
                 bytes_sent, texts_made);
        $display("Checked %0d code points, %0d of them substituted.",
                 points_seen, subst_seen);
        if (err_cnt == 0)
            $display("utf8_validating_decoder_top_test passed");
        else
            $display("utf8_validating_decoder_top_test failed");
        $finish;
    end

endmodule
